/* sv/dcp_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and field widths for the directory compaction planner
// no dependencies
package dcp_pkg;

	localparam int MAX_ENTRIES = 128;

	localparam int ADDR_W  = 16;
	localparam int COUNT_W = 8;
	localparam int BYTE_W  = 8;
	localparam int FREE_W  = 16;
	localparam int SLOT_W  = 8;

	// stream widths, fields packed from bit 0 and tdata padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int IN_TUSER_W  = 8;
	localparam int OUT_FIELD_W = 65;
	localparam int OUT_TDATA_W = 72;
	localparam int OUT_TUSER_W = 1;

	localparam logic [ADDR_W-1:0] START_ADDRESS = 16'h0100;

	// first byte codes of a directory entry
	localparam logic [BYTE_W-1:0] FB_END     = 8'h00;
	localparam logic [BYTE_W-1:0] FB_DELETED = 8'h01;

	// result kinds
	localparam logic KIND_MOVE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_ENTRIES);

	typedef struct packed {
		logic [ADDR_W-1:0] next_free;
		logic [FREE_W-1:0] free_total;
		logic [SLOT_W-1:0] live_count;
		logic              idle;
	} plan_state_t;

	typedef struct packed {
		logic               kind;
		logic [ADDR_W-1:0]  source_address;
		logic [ADDR_W-1:0]  dest_address;
		logic [COUNT_W-1:0] move_count;
		logic [SLOT_W-1:0]  slot_index;
		logic               needs_copy;
		logic [FREE_W-1:0]  free_sectors;
	} plan_result_t;

endpackage

/* sv/dcp_plan.sv */
`timescale 1ns / 1ps
// next-state and result logic for one directory entry
// depends on dcp_pkg
module dcp_plan (
	input  dcp_pkg::plan_state_t               state,
	input  logic [dcp_pkg::FREE_W-1:0]         init_free,
	input  logic [dcp_pkg::BYTE_W-1:0]         entry_first_byte,
	input  logic [dcp_pkg::COUNT_W-1:0]        sector_count,
	input  logic [dcp_pkg::ADDR_W-1:0]         start_address,
	output dcp_pkg::plan_state_t               next_state,
	output dcp_pkg::plan_result_t              result,
	output logic                               result_valid
);
	import dcp_pkg::*;

	logic [11:0] lin_sum;
	logic [ADDR_W-1:0] advanced;

	// linear sector number: track * 16 + sector, then split back
	assign lin_sum  = {state.next_free[15:8], state.next_free[3:0]} + 12'(sector_count);
	assign advanced = {lin_sum[11:4], 4'h0, lin_sum[3:0]};

	always_comb begin
		next_state   = state;
		result       = '0;
		result_valid = 1'b0;
		case (entry_first_byte)
			FB_END: begin
				result.kind         = KIND_SUMMARY;
				result.dest_address = state.next_free;
				result.slot_index   = state.live_count;
				result.free_sectors = state.free_total;
				result_valid        = 1'b1;
				next_state.next_free  = START_ADDRESS;
				next_state.free_total = init_free;
				next_state.live_count = '0;
				next_state.idle       = 1'b1;
			end
			FB_DELETED: begin
				next_state.free_total = state.free_total + FREE_W'(sector_count);
				next_state.idle       = 1'b0;
			end
			default: begin
				result.kind           = KIND_MOVE;
				result.source_address = start_address;
				result.dest_address   = state.next_free;
				result.move_count     = sector_count;
				result.slot_index     = state.live_count;
				result.needs_copy     = (start_address != state.next_free);
				result.free_sectors   = state.free_total;
				result_valid          = 1'b1;
				next_state.next_free  = advanced;
				next_state.idle       = 1'b0;
				if (state.live_count < SLOT_MAX) begin
					next_state.live_count = state.live_count + 1'b1;
				end
			end
		endcase
	end

endmodule

/* sv/directory_compaction_planner_core.sv */
`timescale 1ns / 1ps
// top level of the directory compaction planner: state registers and output skid buffer
// depends on dcp_pkg and dcp_plan
//
// usage:
//   the slave stream takes one directory entry per item: tuser holds the first byte,
//   tdata the sector count and start address. a first byte of 0 ends the directory
//   and yields a summary item, 1 marks a deleted file (no item out, its sectors go
//   to the free total), anything else is a live file and yields a move item.
//   the master stream carries results; tuser is the kind (0 move, 1 summary).
//   the config port loads the initial free sector count; while no pass is under way
//   it also loads the running free total.
// processing and throughput:
//   an item is processed in the cycle it is accepted; its result is registered in the
//   output register, or in the skid register while the output register is held.
//   one item per cycle is accepted while the skid register is empty.
// stall behavior:
//   an output register plus a one-deep skid register let an item be accepted while
//   a result still waits. s_axis_tready is low only while the skid register is full.
// reset:
//   next free address returns to track 1 sector 0, free total and config to 0,
//   live count to 0, both output registers empty.
module directory_compaction_planner_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [dcp_pkg::FREE_W-1:0]         cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sector_count [7:0], start_address [23:8]
	input  logic [dcp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// entry_first_byte [7:0]
	input  logic [dcp_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// source_address [15:0], dest_address [31:16], move_count [39:32],
	// slot_index [47:40], needs_copy [48], free_sectors [64:49], zeros [71:65]
	output logic [dcp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// result_kind [0]
	output logic [dcp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
	import dcp_pkg::*;

	plan_state_t  state_q;
	plan_state_t  next_state;
	plan_result_t result;
	logic         result_valid;
	logic [FREE_W-1:0] init_free_q;

	plan_result_t out_s1;
	logic         out_v_s1;
	plan_result_t skid_q;
	logic         skid_v_q;

	logic in_take;
	logic out_take;
	logic new_res;

	assign s_axis_tready = !skid_v_q;
	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_take = out_v_s1 && m_axis_tready;
	assign new_res  = in_take && result_valid;

	dcp_plan u_plan (
		.state            (state_q),
		.init_free        (init_free_q),
		.entry_first_byte (s_axis_tuser[BYTE_W-1:0]),
		.sector_count     (s_axis_tdata[COUNT_W-1:0]),
		.start_address    (s_axis_tdata[COUNT_W+ADDR_W-1:COUNT_W]),
		.next_state       (next_state),
		.result           (result),
		.result_valid     (result_valid)
	);

	// directory pass state and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.next_free  <= START_ADDRESS;
			state_q.free_total <= '0;
			state_q.live_count <= '0;
			state_q.idle       <= 1'b1;
			init_free_q        <= '0;
		end else begin
			if (in_take) begin
				state_q <= next_state;
			end else if (cfg_wen && state_q.idle) begin
				// free total follows the register only between passes
				state_q.free_total <= cfg_wdata;
			end
			if (cfg_wen) begin
				init_free_q <= cfg_wdata;
			end
		end
	end

	// valid bits of output and skid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// input is held off; drain skid into the output slot
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_s1 || out_take) begin
			out_v_s1 <= new_res;
		end else if (new_res) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				out_s1 <= skid_q;
			end
		end else if (!out_v_s1 || out_take) begin
			if (new_res) begin
				out_s1 <= result;
			end
		end else if (new_res) begin
			skid_q <= result;
		end
	end

	assign m_axis_tvalid = out_v_s1;
	assign m_axis_tuser  = out_s1.kind;
	assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
		out_s1.free_sectors, out_s1.needs_copy, out_s1.slot_index,
		out_s1.move_count, out_s1.dest_address, out_s1.source_address};

endmodule
